>>> rtl/core/wot_pkg.sv
// Shared types and constants of the windowed Otsu threshold block.
// No dependencies; used by windowed_otsu_threshold and wot_mdu.
`timescale 1ns / 1ps
`default_nettype none
package wot_pkg;

    localparam int BIN_COUNT_DEF        = 128;
    localparam int MAX_FRAME_PIXELS_DEF = 2048;

    // window centre clamp and level after reset
    localparam logic [7:0] LEVEL_LO    = 8'd10;
    localparam logic [7:0] LEVEL_HI    = 8'd245;
    localparam logic [7:0] LEVEL_RESET = 8'd80;
    localparam logic [3:0] WIN_STEPS   = 4'd10;  // 11 candidates
    localparam logic [6:0] WIN_HALF    = 7'd5;

    // register reset values
    localparam logic [7:0] OFFSET_RESET  = 8'd0;
    localparam logic [7:0] FLOOR_RESET   = 8'd50;
    localparam logic [7:0] CEILING_RESET = 8'd120;
    localparam logic [7:0] FG_RESET      = 8'd170;

    // register indexes
    localparam logic [1:0] REG_OFFSET  = 2'd0;
    localparam logic [1:0] REG_FLOOR   = 2'd1;
    localparam logic [1:0] REG_CEILING = 2'd2;
    localparam logic [1:0] REG_FG      = 2'd3;

    typedef enum logic {
        MDU_SQR = 1'b0,
        MDU_DIV = 1'b1
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_ctl;

endpackage
`default_nettype wire

>>> rtl/core/windowed_otsu_threshold.sv
// Top level: 128-bin histogram of a frame and windowed Otsu level search.
// Depends on wot_pkg and wot_mdu.
//
// Usage: pixels enter on the i_valid/o_ready request channel, one request per
// pixel, i_frame_end on the last one. Each pixel is a histogram read, then
// a write back of the incremented bin. On the frame_end pixel the block
// searches 11 candidate levels. Each candidate sweeps the histogram memory,
// runs two class terms (each a square, then a divide) through the bit-serial
// unit when both classes are non-empty, and ends in a compare; the unit's
// operands are PW = 2*CW+7 bits wide with CW = clog2(MAX_FRAME_PIXELS+1).
// After the result is registered the memory is cleared, one bin a cycle.
// The result sits in the output register until o_valid/i_ready completes;
// new pixels are taken meanwhile, and only a second frame end waits for the
// pending result to be taken. After reset a clearing pass of the histogram
// runs with o_ready low; register writes on the i_cfg_* port are taken at
// any time.
`timescale 1ns / 1ps
`default_nettype none
module windowed_otsu_threshold #(
    parameter int BIN_COUNT        = wot_pkg::BIN_COUNT_DEF,
    parameter int MAX_FRAME_PIXELS = wot_pkg::MAX_FRAME_PIXELS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [7:0]  i_cfg_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_pixel,
    input  wire         i_frame_end,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [7:0]  o_otsu_level,
    output logic [7:0]  o_applied_level
);
    import wot_pkg::*;

    localparam int BW  = $clog2(BIN_COUNT);
    localparam int CW  = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int SW  = CW + BW;
    localparam int PW  = SW + CW;
    localparam int QW  = 2 * PW;
    localparam int SCW = QW + 1;

    typedef enum logic [12:0] {
        S_CLEAR = 13'h0001,
        S_IDLE  = 13'h0002,
        S_UPD   = 13'h0004,
        S_INIT  = 13'h0008,
        S_SWEEP = 13'h0010,
        S_MA    = 13'h0020,
        S_MB    = 13'h0040,
        S_SQ    = 13'h0080,
        S_SQW   = 13'h0100,
        S_DV    = 13'h0200,
        S_DVW   = 13'h0400,
        S_CMP   = 13'h0800,
        S_FIN   = 13'h1000
    } t_state;

    t_state          r_state;
    logic [7:0]      r_offset, r_floor, r_ceil, r_fg;
    logic [7:0]      r_prev;
    logic [CW-1:0]   r_total;
    logic [BW-1:0]   r_bin;
    logic            r_cnt_en, r_last;
    logic [CW-1:0]   mem [BIN_COUNT];
    logic [CW-1:0]   r_rdata;
    logic [BW:0]     r_addr;
    logic            r_dv;
    logic [BW-1:0]   r_jd;
    logic [CW-1:0]   r_c0, r_c1;
    logic [SW-1:0]   r_s0, r_s1;
    logic [BW-1:0]   r_cand;
    logic [3:0]      r_left;
    logic            r_cls;
    logic [PW-1:0]   r_pa, r_pb;
    logic [SCW-1:0]  r_score, r_best;
    logic [7:0]      r_level;
    logic            r_out_valid;
    logic [7:0]      r_out_otsu, r_out_appl;

    logic            w_accept;
    logic            w_fin_go;
    logic            w_we;
    logic [BW-1:0]   w_wa, w_ra;
    logic [CW-1:0]   w_wd;
    logic [SW-1:0]   w_jprod;
    logic [SW-1:0]   w_s, w_stot;
    logic [CW-1:0]   w_c;
    logic [SW-1:0]   w_mx;
    logic [CW-1:0]   w_my;
    logic [PW-1:0]   w_prod;
    logic [PW-1:0]   w_d;
    logic [7:0]      w_centre_lvl;
    logic [7:0]      w_otsu;
    t_mdu_ctl        w_mctl;
    logic [QW-1:0]   w_mres;
    logic            w_mdone;

    assign w_accept = i_valid && o_ready;
    // result may be loaded once any earlier result is gone or leaves now
    assign w_fin_go = (r_state == S_FIN) && (!r_out_valid || i_ready);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RESET;
            r_floor  <= FLOOR_RESET;
            r_ceil   <= CEILING_RESET;
            r_fg     <= FG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OFFSET:  r_offset <= i_cfg_data;
                REG_FLOOR:   r_floor  <= i_cfg_data;
                REG_CEILING: r_ceil   <= i_cfg_data;
                REG_FG:      r_fg     <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // histogram memory ports
    always_comb begin
        w_we = 1'b0;
        w_wa = r_bin;
        w_wd = r_rdata + 1'b1;
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
            w_wa = r_addr[BW-1:0];
            w_wd = '0;
        end else if (r_state == S_UPD) begin
            w_we = r_cnt_en;
        end
    end
    assign w_ra = (r_state == S_IDLE) ? i_pixel[BW:1] : r_addr[BW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_wa] <= w_wd;
        r_rdata <= mem[w_ra];
    end

    // operand selection for the class-term multiplier
    assign w_jprod = SW'(r_jd) * SW'(r_rdata);
    assign w_s     = r_cls ? r_s1 : r_s0;
    assign w_c     = r_cls ? r_c1 : r_c0;
    assign w_stot  = r_s0 + r_s1;
    assign w_mx    = (r_state == S_MA) ? w_s : w_stot;
    assign w_my    = (r_state == S_MA) ? r_total : w_c;
    assign w_prod  = PW'(w_mx) * PW'(w_my);
    assign w_d     = (r_pa > r_pb) ? (r_pa - r_pb) : (r_pb - r_pa);

    assign w_centre_lvl = (r_prev < LEVEL_LO) ? LEVEL_LO :
                          (r_prev > LEVEL_HI) ? LEVEL_HI : r_prev;

    // clamp: floor first, then ceiling
    always_comb begin
        w_otsu = r_level;
        if (w_otsu < r_floor) w_otsu = r_floor;
        if (w_otsu > r_ceil)  w_otsu = r_ceil;
    end

    always_comb begin
        w_mctl.start = (r_state == S_SQ) || (r_state == S_DV);
        w_mctl.op    = (r_state == S_DV) ? MDU_DIV : MDU_SQR;
    end

    wot_mdu #(.DW(PW), .CW(CW)) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mctl),
        .i_sq    (w_d),
        .i_dvd   (w_mres),
        .i_dvs   (w_c),
        .o_res   (w_mres),
        .o_done  (w_mdone)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_go) begin
            r_out_valid <= 1'b1;
            r_out_otsu  <= w_otsu;
            r_out_appl  <= w_otsu + r_offset;
        end else if (o_valid && i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_total     <= '0;
            r_prev      <= LEVEL_RESET;
            r_dv        <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr[BW-1:0] == BW'(BIN_COUNT - 1)) begin
                        r_state <= S_IDLE;
                        r_total <= '0;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_bin    <= i_pixel[BW:1];
                        r_cnt_en <= r_total < CW'(MAX_FRAME_PIXELS);
                        r_last   <= i_frame_end;
                        if (r_total < CW'(MAX_FRAME_PIXELS)) r_total <= r_total + 1'b1;
                        r_state  <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_state <= r_last ? S_INIT : S_IDLE;
                end
                S_INIT: begin
                    r_cand  <= w_centre_lvl[BW:1] - WIN_HALF;
                    r_left  <= WIN_STEPS;
                    r_best  <= '0;
                    r_level <= '0;
                    r_addr  <= '0;
                    r_dv    <= 1'b0;
                    r_c0 <= '0; r_c1 <= '0; r_s0 <= '0; r_s1 <= '0;
                    r_score <= '0;
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    // issue reads one ahead, accumulate the returned bin
                    if (r_dv) begin
                        if (r_jd <= r_cand) begin
                            r_c0 <= r_c0 + r_rdata;
                            r_s0 <= r_s0 + w_jprod;
                        end else if (8'(r_jd) < (r_fg >> 1)) begin
                            r_c1 <= r_c1 + r_rdata;
                            r_s1 <= r_s1 + w_jprod;
                        end
                    end
                    if (r_addr < (BW+1)'(BIN_COUNT)) begin
                        r_jd   <= r_addr[BW-1:0];
                        r_dv   <= 1'b1;
                        r_addr <= r_addr + 1'b1;
                    end else begin
                        r_dv <= 1'b0;
                        if (!r_dv) begin
                            r_cls   <= 1'b0;
                            r_state <= (r_c0 == '0 || r_c1 == '0) ? S_CMP : S_MA;
                        end
                    end
                end
                S_MA: begin
                    r_pa    <= w_prod;
                    r_state <= S_MB;
                end
                S_MB: begin
                    r_pb    <= w_prod;
                    r_state <= S_SQ;
                end
                S_SQ:  r_state <= S_SQW;
                S_SQW: if (w_mdone) r_state <= S_DV;
                S_DV:  r_state <= S_DVW;
                S_DVW: begin
                    if (w_mdone) begin
                        r_score <= r_score + SCW'(w_mres);
                        if (r_cls) begin
                            r_state <= S_CMP;
                        end else begin
                            r_cls   <= 1'b1;
                            r_state <= S_MA;
                        end
                    end
                end
                S_CMP: begin
                    if (r_score > r_best) begin
                        r_best  <= r_score;
                        r_level <= {r_cand, 1'b0};
                    end
                    r_c0 <= '0; r_c1 <= '0; r_s0 <= '0; r_s1 <= '0;
                    r_score <= '0;
                    r_addr  <= '0;
                    if (r_left == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_left  <= r_left - 1'b1;
                        r_cand  <= r_cand + 1'b1;
                        r_state <= S_SWEEP;
                    end
                end
                S_FIN: begin
                    // wait while an earlier result is still pending
                    if (w_fin_go) begin
                        r_prev      <= w_otsu + r_offset;
                        r_addr      <= '0;
                        r_state     <= S_CLEAR;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_otsu_level    = r_out_otsu;
    assign o_applied_level = r_out_appl;
endmodule
`default_nettype wire

>>> rtl/core/wot_mdu.sv
// Bit-serial square / restoring divide unit, one bit per cycle.
// Depends on wot_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none
module wot_mdu #(
    parameter int DW = 41,
    parameter int CW = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wot_pkg::t_mdu_ctl    i_ctl,
    input  wire  [DW-1:0]        i_sq,
    input  wire  [2*DW-1:0]      i_dvd,
    input  wire  [CW-1:0]        i_dvs,
    output logic [2*DW-1:0]      o_res,
    output logic                 o_done
);
    import wot_pkg::*;

    localparam int QW = 2 * DW;
    localparam int NW = $clog2(QW + 1);

    logic            r_busy;
    t_mdu_op         r_op;
    logic [NW-1:0]   r_cnt;
    logic            r_done;
    logic [QW-1:0]   r_acc;
    logic [QW-1:0]   r_mc;
    logic [DW-1:0]   r_mp;
    logic [CW-1:0]   r_rem;

    logic [NW-1:0]   w_last;
    logic [CW:0]     w_trial;
    logic            w_ge;
    logic [CW:0]     w_diff;

    assign w_last  = (r_op == MDU_SQR) ? NW'(DW - 1) : NW'(QW - 1);
    assign w_trial = {r_rem, r_acc[QW-1]};
    assign w_ge    = w_trial >= {1'b0, i_dvs};
    assign w_diff  = w_trial - {1'b0, i_dvs};

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= MDU_SQR;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_op   <= i_ctl.op;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift-add square or one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            if (i_ctl.op == MDU_SQR) begin
                r_acc <= '0;
                r_mc  <= QW'(i_sq);
                r_mp  <= i_sq;
            end else begin
                r_acc <= i_dvd;
                r_rem <= '0;
            end
        end else if (r_busy) begin
            if (r_op == MDU_SQR) begin
                if (r_mp[0]) r_acc <= r_acc + r_mc;
                r_mc <= {r_mc[QW-2:0], 1'b0};
                r_mp <= {1'b0, r_mp[DW-1:1]};
            end else begin
                r_rem <= w_ge ? w_diff[CW-1:0] : w_trial[CW-1:0];
                r_acc <= {r_acc[QW-2:0], w_ge};
            end
        end
    end

    assign o_res  = r_acc;
    assign o_done = r_done;
endmodule
`default_nettype wire

>>> rtl/core/wot_checker.sv
// Port-level checks of windowed_otsu_threshold and the bind that attaches them.
// Depends on the top level's port list only.
`timescale 1ns / 1ps
`default_nettype none
module wot_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       o_ready,
    input wire       o_valid,
    input wire       i_ready,
    input wire [7:0] o_otsu_level,
    input wire [7:0] o_applied_level
);
    // reset clears the result and holds off requests during the clear pass
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("result or ready active after reset");

    // requests are never accepted back to back
    a_two_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted on back-to-back cycles");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_otsu_level)
                                  && $stable(o_applied_level))
        else $error("pending result changed");
endmodule

bind windowed_otsu_threshold wot_checker u_wot_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_otsu_level    (o_otsu_level),
    .o_applied_level (o_applied_level)
);
`default_nettype wire

>>> dv/tb_windowed_otsu_threshold.sv
// Self-checking testbench of windowed_otsu_threshold: frames of pixels in, one
// threshold pair out per frame end, compared with an internal histogram model.
// Depends on wot_pkg and the windowed_otsu_threshold RTL.
`timescale 1ns / 1ps
module tb_windowed_otsu_threshold;
    import wot_pkg::*;

    localparam int FRAME_CAP   = 256;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 4500;   // one frame-end search plus clearing
    localparam int LONG_HOLD   = 6000;

    typedef struct {
        logic [7:0] otsu;
        logic [7:0] applied;
    } t_levels;

    typedef struct {
        logic [7:0] pixel;
        logic       frame_end;
        logic       typed;
        logic [7:0] otsu;
        logic [7:0] applied;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [7:0] i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic [7:0] i_pixel = '0;
    logic       i_frame_end = 1'b0;
    logic       i_ready = 1'b0;
    logic       o_ready, o_valid;
    logic [7:0] o_otsu_level, o_applied_level;

    // smaller frame cap keeps the overlong-frame case short
    windowed_otsu_threshold #(.MAX_FRAME_PIXELS(FRAME_CAP)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_pixel(i_pixel), .i_frame_end(i_frame_end),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_otsu_level(o_otsu_level), .o_applied_level(o_applied_level)
    );

    always #4 i_clk = ~i_clk;

    // model state
    int unsigned bin_hist[128];
    int unsigned frame_pixels;
    logic [7:0]  last_applied;
    logic [7:0]  cfg_offset, cfg_floor, cfg_ceiling, cfg_fg;

    t_levels level_q[$];
    int  mismatches = 0;
    int  levels_seen = 0;
    int  pixels_sent = 0;
    int  cycles = 0;
    bit  idle_on = 1'b1;
    bit  long_hold = 1'b0;

    // one class term: floor((s*n - S*c)^2 / c)
    function automatic logic [127:0] class_score(longint unsigned s, longint unsigned c,
                                                 longint unsigned n, longint unsigned sum);
        logic [127:0] a, b, d;
        a = s * n;
        b = sum * c;
        d = (a > b) ? a - b : b - a;
        return (d * d) / c;
    endfunction

    // windowed search over the histogram, then clamp and offset
    function automatic t_levels frame_levels();
        t_levels r;
        int unsigned prev, centre, fg_end, lvl;
        longint unsigned c0, s0, c1, s1;
        logic [127:0] best, score;
        prev = last_applied;
        if (prev < LEVEL_LO) prev = LEVEL_LO;
        if (prev > LEVEL_HI) prev = LEVEL_HI;
        centre = prev / 2;
        fg_end = cfg_fg / 2;
        best = '0;
        lvl = 0;
        for (int unsigned i = centre - 5; i <= centre + 5; i++) begin
            c0 = 0; s0 = 0; c1 = 0; s1 = 0;
            for (int unsigned j = 0; j < 128; j++) begin
                if (j <= i) begin
                    c0 += bin_hist[j];
                    s0 += j * bin_hist[j];
                end else if (j < fg_end) begin
                    c1 += bin_hist[j];
                    s1 += j * bin_hist[j];
                end
            end
            if (c0 != 0 && c1 != 0) begin
                score = class_score(s0, c0, frame_pixels, s0 + s1)
                      + class_score(s1, c1, frame_pixels, s0 + s1);
                if (score > best) begin
                    best = score;
                    lvl = i * 2;
                end
            end
        end
        if (lvl < cfg_floor) lvl = cfg_floor;
        if (lvl > cfg_ceiling) lvl = cfg_ceiling;
        r.otsu = lvl[7:0];
        r.applied = r.otsu + cfg_offset;
        return r;
    endfunction

    // model update for one accepted pixel; returns 1 on a frame end
    function automatic bit accept_pixel(logic [7:0] px, logic fe, output t_levels r);
        if (frame_pixels < FRAME_CAP) begin
            bin_hist[px >> 1]++;
            frame_pixels++;
        end
        if (!fe) return 1'b0;
        r = frame_levels();
        last_applied = r.applied;
        foreach (bin_hist[k]) bin_hist[k] = 0;
        frame_pixels = 0;
        return 1'b1;
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_OFFSET:  cfg_offset = data;
            REG_FLOOR:   cfg_floor = data;
            REG_CEILING: cfg_ceiling = data;
            default:     cfg_fg = data;
        endcase
    endtask

    // one pixel request; a typed row overrides the model's expectation
    task automatic send_pixel(logic [7:0] px, logic fe, bit typed = 0, t_levels want = '{0, 0});
        int gap;
        t_levels r;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        repeat (gap) @(negedge i_clk);
        i_valid = 1'b1;
        i_pixel = px;
        i_frame_end = fe;
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
        if (accept_pixel(px, fe, r)) level_q.push_back(typed ? want : r);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // wait for every pending result, then for the block to go quiet
    task automatic drain();
        while (level_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // frame mostly from two gray clusters around the last level, some noise
    task automatic send_frame(int len);
        int lo_c, hi_c, v;
        lo_c = int'(last_applied) - $urandom_range(4, 40);
        hi_c = int'(last_applied) + $urandom_range(4, 40);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
                0:       v = $urandom_range(0, 255);
                1, 2, 3: v = hi_c + $urandom_range(0, 16) - 8;
                default: v = lo_c + $urandom_range(0, 16) - 8;
            endcase
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            send_pixel(v[7:0], k == len - 1);
        end
    endtask

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            levels_seen++;
            if (level_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result otsu=%0d applied=%0d",
                             o_otsu_level, o_applied_level);
            end else begin
                t_levels e;
                e = level_q.pop_front();
                if (e.otsu !== o_otsu_level || e.applied !== o_applied_level) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: otsu exp %0d got %0d, applied exp %0d got %0d",
                                 e.otsu, o_otsu_level, e.applied, o_applied_level);
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        int w;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold = 1'b0;
            end
            w = idle_on ? $urandom_range(0, 19) : 0;
            if (w > 0) begin
                i_ready = 1'b0;
                repeat (w) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_windowed_otsu_threshold failed");
            $finish;
        end
    end

    // directed rows; single-pixel frames have no winner, so the floor comes out
    t_row directed[] = '{
        '{8'd0,   1'b1, 1'b1, 8'd50, 8'd50},
        '{8'd255, 1'b1, 1'b1, 8'd50, 8'd50},
        '{8'd0,   1'b0, 1'b0, 8'd0,  8'd0},
        '{8'd255, 1'b1, 1'b1, 8'd50, 8'd50},
        '{8'd60,  1'b0, 1'b0, 8'd0,  8'd0},
        '{8'd60,  1'b0, 1'b0, 8'd0,  8'd0},
        '{8'd62,  1'b0, 1'b0, 8'd0,  8'd0},
        '{8'd100, 1'b0, 1'b0, 8'd0,  8'd0},
        '{8'd102, 1'b0, 1'b0, 8'd0,  8'd0},
        '{8'd104, 1'b1, 1'b0, 8'd0,  8'd0},
        '{8'd40,  1'b0, 1'b0, 8'd0,  8'd0},
        '{8'd44,  1'b0, 1'b0, 8'd0,  8'd0},
        '{8'd48,  1'b0, 1'b0, 8'd0,  8'd0},
        '{8'd52,  1'b0, 1'b0, 8'd0,  8'd0},
        '{8'd56,  1'b0, 1'b0, 8'd0,  8'd0},
        '{8'd85,  1'b0, 1'b0, 8'd0,  8'd0},
        '{8'd170, 1'b0, 1'b0, 8'd0,  8'd0},
        '{8'd171, 1'b1, 1'b0, 8'd0,  8'd0}
    };

    // register settings per phase: offset, floor, ceiling, foreground limit
    logic [7:0] phase_cfg[][4] = '{
        '{8'd0,   8'd50,  8'd120, 8'd170},
        '{8'd128, 8'd0,   8'd255, 8'd255},
        '{8'd127, 8'd255, 8'd255, 8'd0},
        '{8'd251, 8'd200, 8'd100, 8'd200},
        '{8'd7,   8'd0,   8'd0,   8'd128},
        '{8'd0,   8'd20,  8'd240, 8'd255},
        '{8'd200, 8'd30,  8'd180, 8'd150}
    };

    initial begin
        int random_pixels;
        int len;
        cfg_offset = OFFSET_RESET;
        cfg_floor = FLOOR_RESET;
        cfg_ceiling = CEILING_RESET;
        cfg_fg = FG_RESET;
        last_applied = LEVEL_RESET;
        frame_pixels = 0;
        foreach (bin_hist[k]) bin_hist[k] = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[r])
            send_pixel(directed[r].pixel, directed[r].frame_end, directed[r].typed,
                       '{directed[r].otsu, directed[r].applied});
        drain();

        // overlong frame: pixels past the cap are dropped
        send_frame(FRAME_CAP + 9);

        random_pixels = 0;
        foreach (phase_cfg[p]) begin
            drain();
            for (int k = 0; k < 4; k++) cfg_write(k[1:0], phase_cfg[p][k]);
            idle_on = (p != 5);
            if (p == 2) long_hold = 1'b1;
            while (random_pixels < (p + 1) * 224) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(1, 30);
                send_frame(len);
                random_pixels += len;
            end
        end

        drain();
        $display("covered %0d pixels, %0d threshold results, %0d register settings",
                 pixels_sent, levels_seen, phase_cfg.size() + 1);
        if (level_q.size() != 0) begin
            $display("%0d results never arrived", level_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("tb_windowed_otsu_threshold passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb_windowed_otsu_threshold failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/wot_pkg.sv
rtl/core/wot_mdu.sv
rtl/core/windowed_otsu_threshold.sv
rtl/core/wot_checker.sv
dv/tb_windowed_otsu_threshold.sv
